FILE: rtl/kaap_pkg.sv
package kaap_pkg;

  localparam int HOLD_BITS = 16;
  localparam int ACC_BITS  = 11;
  localparam int CFG_BITS  = 10;
  localparam int DT_BITS   = 8;

  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
  localparam logic [DT_BITS-1:0]  DT_MAX  = 8'd250;

  localparam logic [CFG_BITS-1:0] START_DELAY_RST   = 10'd150;
  localparam logic [CFG_BITS-1:0] REPEAT_PERIOD_RST = 10'd50;
  localparam logic [CFG_BITS-1:0] DROP_PERIOD_RST   = 10'd33;

  localparam int CFG_ADDR_BITS = 4;

  typedef enum logic [1:0] {
    REG_START_DELAY   = 2'd0,
    REG_REPEAT_PERIOD = 2'd1,
    REG_DROP_PERIOD   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_QUIT = 2'd1,
    EV_HARD = 2'd2,
    EV_ROT  = 2'd3
  } edge_ev_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_QUIT  = 3'd1,
    ACT_HARD  = 3'd2,
    ACT_ROT   = 3'd3,
    ACT_DOWN  = 3'd4,
    ACT_LEFT  = 3'd5,
    ACT_RIGHT = 3'd6
  } action_t;

  typedef struct packed {
    logic                 fire;
    logic [HOLD_BITS-1:0] hold;
    logic [ACC_BITS-1:0]  rep;
  } side_res_t;

endpackage

FILE: rtl/key_autorepeat_action_picker.sv
// A request is accepted into the input register; its action is then registered in the
// result register, which drives out_tdata. Throughput: one request per cycle unless an
// action waits for out_tready; the input register then takes one more request and stalls.
// The timers and accumulators are updated in the same cycle the action is registered.
// Reset (rst_n low, synchronous) empties both stages, zeroes all timers and loads
// the register defaults 150, 50 and 33.
module key_autorepeat_action_picker
  import kaap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [10:0] elapsed_ms, [12:11] edge_event, [13] left_level, [14] right_level,
  // [15] down_level
  input  logic [15:0]              in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [2:0] action, [7:3] zero
  output logic [7:0]               out_tdata,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  // Configuration registers
  logic [CFG_BITS-1:0] start_delay_r, repeat_period_r, drop_period_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r   <= START_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
      drop_period_r   <= DROP_PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_DELAY:   start_delay_r   <= cfg_pwdata[CFG_BITS-1:0];
        REG_REPEAT_PERIOD: repeat_period_r <= cfg_pwdata[CFG_BITS-1:0];
        REG_DROP_PERIOD:   drop_period_r   <= cfg_pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_DELAY:   cfg_prdata = {22'd0, start_delay_r};
      REG_REPEAT_PERIOD: cfg_prdata = {22'd0, repeat_period_r};
      REG_DROP_PERIOD:   cfg_prdata = {22'd0, drop_period_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // Input register
  logic        s1_valid_r;
  logic [10:0] s1_elapsed_r;
  edge_ev_t    s1_event_r;
  logic        s1_left_r, s1_right_r, s1_down_r;
  logic        out_valid_r;
  action_t     out_action_r;
  logic        adv, s1_fire;

  assign adv       = ~out_valid_r | out_tready;
  assign s1_fire   = s1_valid_r & adv;
  assign in_tready = ~s1_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_elapsed_r <= in_tdata[10:0];
      s1_event_r   <= edge_ev_t'(in_tdata[12:11]);
      s1_left_r    <= in_tdata[13];
      s1_right_r   <= in_tdata[14];
      s1_down_r    <= in_tdata[15];
    end
  end

  // Timer state
  logic [ACC_BITS-1:0]  drop_accum_r, drop_accum_nxt;
  logic [HOLD_BITS-1:0] left_hold_r, left_hold_nxt, right_hold_r, right_hold_nxt;
  logic [ACC_BITS-1:0]  left_rep_r, left_rep_nxt, right_rep_r, right_rep_nxt;

  function automatic side_res_t side_step(
    input logic                 held,
    input logic [DT_BITS-1:0]   dt,
    input logic [HOLD_BITS-1:0] hold,
    input logic [ACC_BITS-1:0]  rep,
    input logic [CFG_BITS-1:0]  start,
    input logic [CFG_BITS-1:0]  period
  );
    side_res_t            res;
    logic [HOLD_BITS:0]   hold_sum;
    logic [HOLD_BITS-1:0] hold_new;
    logic [ACC_BITS:0]    rep_sum;
    logic [ACC_BITS-1:0]  rep_new;
    res.fire = 1'b0;
    res.hold = '0;
    res.rep  = '0;
    hold_sum = {1'b0, hold} + (HOLD_BITS+1)'(dt);
    hold_new = hold_sum[HOLD_BITS] ? {HOLD_BITS{1'b1}} : hold_sum[HOLD_BITS-1:0];
    rep_sum  = {1'b0, rep} + (ACC_BITS+1)'(dt);
    rep_new  = rep_sum[ACC_BITS] ? ACC_MAX : rep_sum[ACC_BITS-1:0];
    if (held) begin
      res.hold = hold_new;
      res.rep  = rep;
      // The first move comes on the tick where the hold time is just this tick's time.
      if (hold_new == HOLD_BITS'(dt)) begin
        res.rep  = '0;
        res.fire = 1'b1;
      end else if (hold_new >= HOLD_BITS'(start)) begin
        if (rep_new >= ACC_BITS'(period)) begin
          res.rep  = rep_new - ACC_BITS'(period);
          res.fire = 1'b1;
        end else begin
          res.rep = rep_new;
        end
      end
    end
    return res;
  endfunction

  logic [DT_BITS-1:0]  dt;
  logic                left_eff, right_eff;
  logic [ACC_BITS:0]   drop_sum;
  logic [ACC_BITS-1:0] drop_sat;
  logic                drop_fire;
  side_res_t           left_res, right_res;
  action_t             action_nxt;

  always_comb begin
    if (s1_elapsed_r[10]) begin
      dt = '0;
    end else if (s1_elapsed_r[9:0] > 10'(DT_MAX)) begin
      dt = DT_MAX;
    end else begin
      dt = s1_elapsed_r[DT_BITS-1:0];
    end
  end

  assign left_eff  = s1_left_r & ~s1_right_r;
  assign right_eff = s1_right_r & ~s1_left_r;
  assign drop_sum  = {1'b0, drop_accum_r} + (ACC_BITS+1)'(dt);
  assign drop_sat  = drop_sum[ACC_BITS] ? ACC_MAX : drop_sum[ACC_BITS-1:0];
  assign drop_fire = s1_down_r & (drop_sat >= ACC_BITS'(drop_period_r));

  assign left_res  = side_step(left_eff, dt, left_hold_r, left_rep_r,
                               start_delay_r, repeat_period_r);
  assign right_res = side_step(right_eff, dt, right_hold_r, right_rep_r,
                               start_delay_r, repeat_period_r);

  always_comb begin
    drop_accum_nxt = drop_accum_r;
    left_hold_nxt  = left_hold_r;
    left_rep_nxt   = left_rep_r;
    right_hold_nxt = right_hold_r;
    right_rep_nxt  = right_rep_r;
    if (s1_event_r != EV_NONE) begin
      action_nxt = action_t'({1'b0, s1_event_r});
    end else if (drop_fire) begin
      action_nxt     = ACT_DOWN;
      drop_accum_nxt = '0;
    end else begin
      drop_accum_nxt = s1_down_r ? drop_sat : '0;
      left_hold_nxt  = left_res.hold;
      left_rep_nxt   = left_res.rep;
      if (left_res.fire) begin
        action_nxt = ACT_LEFT;
      end else begin
        right_hold_nxt = right_res.hold;
        right_rep_nxt  = right_res.rep;
        action_nxt     = right_res.fire ? ACT_RIGHT : ACT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_accum_r <= '0;
      left_hold_r  <= '0;
      left_rep_r   <= '0;
      right_hold_r <= '0;
      right_rep_r  <= '0;
    end else if (s1_fire) begin
      drop_accum_r <= drop_accum_nxt;
      left_hold_r  <= left_hold_nxt;
      left_rep_r   <= left_rep_nxt;
      right_hold_r <= right_hold_nxt;
      right_rep_r  <= right_rep_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_action_r <= action_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_action_r};

  // Checks
  a_event_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_event_r != EV_NONE |=> $stable(drop_accum_r) && $stable(left_hold_r)
      && $stable(left_rep_r) && $stable(right_hold_r) && $stable(right_rep_r))
    else $error("timer state changed on an edge event request");

  a_event_passes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_event_r != EV_NONE |=> out_tdata[1:0] == $past(s1_event_r)
      && out_tdata[2] == 1'b0)
    else $error("edge event not returned as the action");

  a_left_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && action_nxt == ACT_LEFT |-> s1_left_r && !s1_right_r)
    else $error("left move without left key held alone");

  a_right_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && action_nxt == ACT_RIGHT |-> s1_right_r && !s1_left_r)
    else $error("right move without right key held alone");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import kaap_pkg::*;

  localparam int unsigned HOLD_MAX = (1 << HOLD_BITS) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // [10:0] elapsed_ms, [12:11] edge_event, [13] left_level, [14] right_level,
  // [15] down_level
  logic [15:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // [2:0] action, [7:3] zero
  logic [7:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Register copies and timer state of the behavioral model.
  logic [CFG_BITS-1:0] cfg_start;
  logic [CFG_BITS-1:0] cfg_repeat;
  logic [CFG_BITS-1:0] cfg_drop;
  logic [ACC_BITS-1:0] drop_acc;
  logic [HOLD_BITS-1:0] left_hold;
  logic [ACC_BITS-1:0] left_rep;
  logic [HOLD_BITS-1:0] right_hold;
  logic [ACC_BITS-1:0] right_rep;

  action_t expected_actions[$];
  int errors;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  key_autorepeat_action_picker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One horizontal key. Returns 1 when the key produces a move on this tick.
  function automatic bit side_move(input bit held, input logic [DT_BITS-1:0] dt,
                                   inout logic [HOLD_BITS-1:0] hold,
                                   inout logic [ACC_BITS-1:0] rep);
    int unsigned sum;
    if (!held) begin
      hold = '0;
      rep = '0;
      return 1'b0;
    end
    sum = hold + dt;
    hold = (sum > HOLD_MAX) ? HOLD_MAX[HOLD_BITS-1:0] : sum[HOLD_BITS-1:0];
    if (hold == dt) begin
      rep = '0;
      return 1'b1;
    end
    if (hold >= cfg_start) begin
      sum = rep + dt;
      rep = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_BITS-1:0];
      if (rep >= cfg_repeat) begin
        rep = rep - cfg_repeat;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic action_t next_action(input logic [15:0] tick);
    logic [10:0] raw;
    edge_ev_t ev;
    bit left_key;
    bit right_key;
    bit down_key;
    logic [DT_BITS-1:0] dt;
    int unsigned sum;
    raw = tick[10:0];
    ev = edge_ev_t'(tick[12:11]);
    left_key = tick[13];
    right_key = tick[14];
    down_key = tick[15];
    // Negative elapsed time counts as zero, large values clamp.
    if (raw[10])
      dt = '0;
    else if (raw > 11'(DT_MAX))
      dt = DT_MAX;
    else
      dt = raw[DT_BITS-1:0];

    case (ev)
      EV_QUIT: return ACT_QUIT;
      EV_HARD: return ACT_HARD;
      EV_ROT:  return ACT_ROT;
      default: ;
    endcase

    if (left_key && right_key) begin
      left_key = 1'b0;
      right_key = 1'b0;
    end

    if (down_key) begin
      sum = drop_acc + dt;
      drop_acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_BITS-1:0];
      if (drop_acc >= cfg_drop) begin
        drop_acc = '0;
        return ACT_DOWN;
      end
    end else begin
      drop_acc = '0;
    end

    if (side_move(left_key, dt, left_hold, left_rep))
      return ACT_LEFT;
    if (side_move(right_key, dt, right_hold, right_rep))
      return ACT_RIGHT;
    return ACT_NONE;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking, expectation bookkeeping and the watchdog share one process,
  // so the result of a request is always checked against an earlier expectation.
  always @(posedge clk) begin
    action_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_actions.size() == 0) begin
          errors++;
          $error("action: unexpected result %0d with nothing expected", out_tdata[2:0]);
        end else begin
          want = expected_actions.pop_front();
          if (out_tdata[2:0] !== want) begin
            errors++;
            $error("action mismatch: expected %0d, got %0d", want, out_tdata[2:0]);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_actions.push_back(next_action(in_tdata));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 52; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 52; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  task automatic send_tick(input logic [10:0] elapsed, input edge_ev_t ev,
                           input bit left_key, input bit right_key, input bit down_key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {down_key, right_key, left_key, ev, elapsed};
    do
      @(posedge clk);
    while (!(in_tvalid && in_tready));
  endtask

  // Stops the stream and lets every pending action drain out.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_actions.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_read(input reg_idx_t idx, output logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] want);
    logic [31:0] data;
    cfg_read(idx, data);
    if (data[CFG_BITS-1:0] !== want) begin
      errors++;
      $error("register %s mismatch: expected %0d, got %0d", idx.name(), want,
             data[CFG_BITS-1:0]);
    end
  endtask

  // Upper write-data bits are random junk; only the low ten bits are kept.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_BITS-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {22'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_START_DELAY:   cfg_start = value;
      REG_REPEAT_PERIOD: cfg_repeat = value;
      default:           cfg_drop = value;
    endcase
    @(posedge clk);
    check_reg(idx, value);
  endtask

  task automatic apply_timing(input logic [CFG_BITS-1:0] start_delay,
                              input logic [CFG_BITS-1:0] repeat_period,
                              input logic [CFG_BITS-1:0] drop_period);
    wait_idle();
    cfg_write(REG_START_DELAY, start_delay);
    cfg_write(REG_REPEAT_PERIOD, repeat_period);
    cfg_write(REG_DROP_PERIOD, drop_period);
  endtask

  task automatic test_register_defaults();
    check_reg(REG_START_DELAY, START_DELAY_RST);
    check_reg(REG_REPEAT_PERIOD, REPEAT_PERIOD_RST);
    check_reg(REG_DROP_PERIOD, DROP_PERIOD_RST);
  endtask

  // Edge events win over any held key and leave all timers alone.
  task automatic test_edge_events();
    set_idling(0);
    send_tick(11'h3FF, EV_QUIT, 1'b1, 1'b1, 1'b1);
    send_tick(11'h400, EV_HARD, 1'b0, 1'b0, 1'b0);
    send_tick(11'd250, EV_ROT, 1'b1, 1'b0, 1'b1);
    send_tick(11'h7FF, EV_NONE, 1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_held_keys();
    set_idling(3);
    // A zero elapsed time keeps the hold time at zero, so the first move repeats.
    repeat (3) send_tick(11'd0, EV_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(11'd251, EV_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(11'd100, EV_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(11'd1023, EV_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(11'd5, EV_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(11'd20, EV_NONE, 1'b0, 1'b1, 1'b0);
    send_tick(11'd20, EV_NONE, 1'b0, 1'b1, 1'b0);
    // Left and right together cancel each other and clear both sides.
    send_tick(11'd20, EV_NONE, 1'b1, 1'b1, 1'b0);
    send_tick(11'd10, EV_NONE, 1'b0, 1'b1, 1'b0);
    // A soft drop takes priority and leaves the horizontal timers untouched.
    send_tick(11'd20, EV_NONE, 1'b1, 1'b0, 1'b1);
    send_tick(11'd20, EV_NONE, 1'b1, 1'b0, 1'b1);
    send_tick(11'h7FD, EV_NONE, 1'b1, 1'b0, 1'b1);
    send_tick(11'd40, EV_NONE, 1'b0, 1'b1, 1'b1);
    wait_idle();
  endtask

  // Mostly realistic play: keys held over many ticks with small time steps,
  // mixed with occasional edge events, odd time values and pure noise.
  task automatic test_random_play(input int count, input int phase);
    bit left_key;
    bit right_key;
    bit down_key;
    logic [10:0] elapsed;
    edge_ev_t ev;
    int unsigned pick;
    left_key = 1'b0;
    right_key = 1'b0;
    down_key = 1'b0;
    set_idling(phase);
    repeat (count) begin
      if ($urandom_range(7) == 0) left_key = ~left_key;
      if ($urandom_range(9) == 0) right_key = ~right_key;
      if ($urandom_range(7) == 0) down_key = ~down_key;
      pick = $urandom_range(99);
      if (pick < 10)
        elapsed = '0;
      else if (pick < 80)
        elapsed = 11'($urandom_range(1, 40));
      else if (pick < 90)
        elapsed = 11'($urandom_range(41, 300));
      else
        elapsed = 11'($urandom_range(2047));
      ev = ($urandom_range(99) < 10) ? edge_ev_t'($urandom_range(1, 3)) : EV_NONE;
      if ($urandom_range(99) < 5)
        send_tick(11'($urandom), edge_ev_t'($urandom_range(3)), 1'($urandom),
                  1'($urandom), 1'($urandom));
      else
        send_tick(elapsed, ev, left_key, right_key, down_key);
    end
    wait_idle();
  endtask

  // Holding one key long enough with large steps saturates its hold timer.
  task automatic test_long_hold();
    set_idling(1);
    repeat (270) send_tick(11'($urandom_range(250, 1023)), EV_NONE, 1'b1, 1'b0, 1'b0);
    repeat (4) send_tick(11'd250, EV_NONE, 1'b1, 1'b0, 1'b1);
    send_tick(11'd7, EV_NONE, 1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    cfg_start = START_DELAY_RST;
    cfg_repeat = REPEAT_PERIOD_RST;
    cfg_drop = DROP_PERIOD_RST;
    drop_acc = '0;
    left_hold = '0;
    left_rep = '0;
    right_hold = '0;
    right_rep = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_edge_events();
    test_held_keys();
    test_random_play(160, 0);
    apply_timing(10'd0, 10'd1, 10'd1);
    test_random_play(160, 1);
    apply_timing(10'd1023, 10'd1023, 10'd1023);
    test_random_play(160, 2);
    // Zero periods make the compares pass on every tick.
    apply_timing(10'd0, 10'd0, 10'd0);
    test_random_play(160, 3);
    apply_timing(10'($urandom_range(1023)), 10'($urandom_range(1, 1023)),
                 10'($urandom_range(1, 1023)));
    test_random_play(160, 0);
    test_long_hold();

    wait_idle();
    repeat (5) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
